// ===== design/hfd_pkg.sv =====
package hfd_pkg;

  localparam int unsigned NODES_DEF       = 512;
  localparam int unsigned STACK_DEPTH_DEF = 256;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = OP_W;
  localparam int unsigned OUT_DATA_W = SYM_W;
  localparam int unsigned OUT_USER_W = STAT_W;

  localparam logic [OP_W-1:0] OP_NODE  = 2'd0;
  localparam logic [OP_W-1:0] OP_BIT   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_TREE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_ent_t;

endpackage

// ===== design/huffman_tree_load_and_decode_core.sv =====
// Huffman tree loader and bit-serial decoder. Each request on the in_ stream is a tree node
// (pre-order: leaf with byte symbol, or internal node), a coded bit, or a tree clear. Node
// entries and right-child links sit in a synchronous memory; internal nodes that wait
// for a right child sit in a second one used as a stack. On acceptance a request issues
// the memory read (the next walk node, or the stack top); in the execute state it then
// updates the walk pointer or writes the new node and link. One request is in flight at a
// time, so a coded bit always sees the node reached by the one before. The result
// register lets the next request in while a result waits; a result held back by out_tready
// stalls a later request's result in the execute state. Status in out_tuser: 0 symbol, 1 no
// complete tree, 2 tree overflow or extra node. A single-leaf tree yields its symbol for
// every coded bit.
module huffman_tree_load_and_decode_core #(
  parameter int unsigned NODES       = hfd_pkg::NODES_DEF,
  parameter int unsigned STACK_DEPTH = hfd_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hfd_pkg::IN_DATA_W-1:0]   in_tdata,   // bit_req, leaf_symbol, zero pad
  input  logic [hfd_pkg::IN_USER_W-1:0]   in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hfd_pkg::OUT_DATA_W-1:0]  out_tdata,  // symbol
  output logic [hfd_pkg::OUT_USER_W-1:0]  out_tuser   // status
);
  import hfd_pkg::*;

  localparam int unsigned IDXW = $clog2(NODES);
  localparam int unsigned CNTW = $clog2(NODES + 1);
  localparam int unsigned SPW  = $clog2(STACK_DEPTH);
  localparam int unsigned LVLW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic              bit_r;
  logic [SYM_W-1:0]  sym_r;
  logic [LVLW-1:0]   lvl_r, lvl_nxt;
  logic [CNTW-1:0]   used_r, used_nxt;
  logic              ready_r, ready_nxt;
  logic [IDXW-1:0]   walk_r, walk_nxt;
  logic [IDXW-1:0]   walk_rt_r, walk_rt_nxt;
  logic              root_leaf_r, root_leaf_nxt;
  logic [SYM_W-1:0]  root_sym_r, root_sym_nxt;
  logic [IDXW-1:0]   root_rt_r, root_rt_nxt;
  logic              last_leaf_r, last_leaf_nxt;
  logic [IDXW-1:0]   next_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic              in_acc;
  logic [OP_W-1:0]   in_op;
  logic              in_bit;
  logic [SYM_W-1:0]  in_sym;
  logic [CNTW-1:0]   step_w;
  logic [IDXW-1:0]   step_idx;
  logic [LVLW-1:0]   lvl_m1;

  node_ent_t         rd_ent;
  logic [IDXW-1:0]   rd_rt;
  logic              ent_we;
  node_ent_t         ent_wdata;
  logic              rt_we;
  logic [IDXW-1:0]   stk_rd;
  logic              push_we;
  logic [SPW-1:0]    push_addr;

  logic              exec;
  logic              full;
  logic              after_leaf;
  logic              stk_full;
  logic              pop;
  logic [LVLW-1:0]   lvl_pop;
  logic              load_rej;
  logic              res_v;
  logic              go;
  logic [IDXW-1:0]   idx;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign in_bit    = in_tdata[0];
  assign in_sym    = in_tdata[SYM_W:1];

  always_comb begin
    step_w = in_bit ? CNTW'(walk_rt_r) : CNTW'(walk_r) + CNTW'(1);
    if (step_w >= used_r) begin
      step_w = '0;
    end
    step_idx = step_w[IDXW-1:0];
  end

  assign lvl_m1 = lvl_r - LVLW'(1);

  hfd_node_store #(.NODES(NODES)) u_node_store (
    .clk       (clk),
    .rd_en     (in_acc && (in_op == OP_BIT)),
    .rd_addr   (step_idx),
    .rd_ent    (rd_ent),
    .rd_rt     (rd_rt),
    .ent_we    (ent_we),
    .ent_addr  (idx),
    .ent_wdata (ent_wdata),
    .rt_we     (rt_we),
    .rt_addr   (stk_rd),
    .rt_wdata  (idx)
  );

  hfd_stack #(.NODES(NODES), .STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .rd_en   (in_acc && (in_op == OP_NODE)),
    .rd_addr (lvl_m1[SPW-1:0]),
    .rd_data (stk_rd),
    .wr_en   (push_we),
    .wr_addr (push_addr),
    .wr_data (idx)
  );

  always_comb begin
    exec       = (state_r == S_EXEC);
    idx        = used_r[IDXW-1:0];
    full       = (used_r == CNTW'(NODES));
    after_leaf = (used_r != '0) && last_leaf_r;
    stk_full   = (lvl_r == LVLW'(STACK_DEPTH));
    pop        = after_leaf && (lvl_r != '0);
    lvl_pop    = pop ? lvl_m1 : lvl_r;
    load_rej   = ready_r || full || (!bit_r && !after_leaf && stk_full);
    res_v      = ((op_r == OP_NODE) && load_rej) ||
                 ((op_r == OP_BIT) && (!ready_r || root_leaf_r || rd_ent.leaf));
    go         = exec && (!res_v || !out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    used_nxt      = used_r;
    ready_nxt     = ready_r;
    walk_nxt      = walk_r;
    walk_rt_nxt   = walk_rt_r;
    root_leaf_nxt = root_leaf_r;
    root_sym_nxt  = root_sym_r;
    root_rt_nxt   = root_rt_r;
    last_leaf_nxt = last_leaf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_stat_nxt  = out_stat_r;
    ent_we        = 1'b0;
    ent_wdata     = '{leaf: bit_r, sym: sym_r};
    rt_we         = 1'b0;
    push_we       = 1'b0;
    push_addr     = lvl_pop[SPW-1:0];

    if (in_acc) begin
      state_nxt = S_EXEC;
    end

    if (go) begin
      state_nxt = S_IDLE;
      case (op_r)
        OP_NODE: begin
          if (load_rej) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = '0;
            out_stat_nxt  = STAT_OVERFLOW;
          end else begin
            ent_we = 1'b1;
            rt_we  = pop;
            if (pop && (stk_rd == '0)) begin
              root_rt_nxt = idx;
            end
            if (idx == '0) begin
              root_leaf_nxt = bit_r;
              root_sym_nxt  = sym_r;
            end
            push_we       = !bit_r;
            lvl_nxt       = bit_r ? lvl_pop : lvl_pop + LVLW'(1);
            used_nxt      = used_r + CNTW'(1);
            last_leaf_nxt = bit_r;
            if (bit_r && (lvl_pop == '0)) begin
              ready_nxt   = 1'b1;
              walk_nxt    = '0;
              walk_rt_nxt = root_rt_nxt;
            end
          end
        end
        OP_BIT: begin
          if (!ready_r) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = '0;
            out_stat_nxt  = STAT_NO_TREE;
          end else if (root_leaf_r) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = root_sym_r;
            out_stat_nxt  = STAT_OK;
          end else if (rd_ent.leaf) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = rd_ent.sym;
            out_stat_nxt  = STAT_OK;
            walk_nxt      = '0;
            walk_rt_nxt   = root_rt_r;
          end else begin
            walk_nxt    = next_r;
            walk_rt_nxt = rd_rt;
          end
        end
        OP_CLEAR: begin
          lvl_nxt   = '0;
          used_nxt  = '0;
          ready_nxt = 1'b0;
          walk_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      used_r      <= '0;
      ready_r     <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      used_r      <= used_nxt;
      ready_r     <= ready_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      bit_r  <= in_bit;
      sym_r  <= in_sym;
      next_r <= step_idx;
    end
    walk_rt_r   <= walk_rt_nxt;
    root_leaf_r <= root_leaf_nxt;
    root_sym_r  <= root_sym_nxt;
    root_rt_r   <= root_rt_nxt;
    last_leaf_r <= last_leaf_nxt;
    out_sym_r   <= out_sym_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_stat_r;

`ifndef ASSERT_OFF
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_ready_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (lvl_r == '0))
    else $error("complete tree with pending internal nodes");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_r <= LVLW'(STACK_DEPTH)) && (used_r <= CNTW'(NODES)))
    else $error("stack level or node count out of range");

  a_no_tree_status: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (op_r == OP_BIT) && !ready_r) |=> (out_tvalid && (out_tuser == STAT_NO_TREE)))
    else $error("coded bit without tree did not report no tree");
`endif

endmodule

// ===== design/hfd_node_store.sv =====
module hfd_node_store #(
  parameter int unsigned NODES = hfd_pkg::NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(NODES)-1:0]   rd_addr,
  output hfd_pkg::node_ent_t         rd_ent,
  output logic [$clog2(NODES)-1:0]   rd_rt,
  input  logic                       ent_we,
  input  logic [$clog2(NODES)-1:0]   ent_addr,
  input  hfd_pkg::node_ent_t         ent_wdata,
  input  logic                       rt_we,
  input  logic [$clog2(NODES)-1:0]   rt_addr,
  input  logic [$clog2(NODES)-1:0]   rt_wdata
);
  import hfd_pkg::*;

  localparam int unsigned IDXW = $clog2(NODES);

  node_ent_t       ent_mem [NODES];
  logic [IDXW-1:0] rt_mem  [NODES];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (rd_en) begin
      rd_ent <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_addr] <= rt_wdata;
    end
    if (rd_en) begin
      rd_rt <= rt_mem[rd_addr];
    end
  end

endmodule

// ===== design/hfd_stack.sv =====
module hfd_stack #(
  parameter int unsigned NODES       = hfd_pkg::NODES_DEF,
  parameter int unsigned STACK_DEPTH = hfd_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]   rd_addr,
  output logic [$clog2(NODES)-1:0]         rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]   wr_addr,
  input  logic [$clog2(NODES)-1:0]         wr_data
);
  import hfd_pkg::*;

  localparam int unsigned IDXW = $clog2(NODES);

  logic [IDXW-1:0] stk_mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stk_mem[rd_addr];
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hfd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam int unsigned     NODE_CNT      = NODES_DEF;
  localparam int unsigned     STACK_CNT     = STACK_DEPTH_DEF;
  localparam int unsigned     LEAF_POS      = 18;
  localparam int unsigned     RANDOM_ITEMS  = 1850;
  localparam int unsigned     MAX_GAP       = 18;
  localparam int unsigned     SETTLE_CYCLES = 10;
  localparam int unsigned     MAX_REPORTS   = 10;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [STAT_W-1:0] stat;
  } decode_res_t;

  class decode_scoreboard;
    bit [18:0]   node_mem [NODE_CNT];
    bit [9:0]    pend_mem [STACK_CNT];
    int unsigned pend_lvl;
    int unsigned used_cnt;
    int unsigned walk_idx;
    bit          tree_done;
    decode_res_t decodes_due [$];
    int unsigned mismatches;

    function void push_decode(logic [SYM_W-1:0] sym, logic [STAT_W-1:0] stat);
      decode_res_t res;
      res.sym  = sym;
      res.stat = stat;
      decodes_due = {decodes_due, res};
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic b, logic [SYM_W-1:0] sym);
      int unsigned idx;
      int unsigned parent;
      int unsigned cur;
      int unsigned nxt;
      bit          after_leaf;
      bit [18:0]   ent;
      case (op)
        OP_NODE: begin
          idx = used_cnt;
          if (tree_done || idx >= NODE_CNT) begin
            push_decode('0, STAT_OVERFLOW);
          end else begin
            after_leaf = (idx > 0) && node_mem[idx-1][LEAF_POS];
            if (!b && !after_leaf && pend_lvl >= STACK_CNT) begin
              push_decode('0, STAT_OVERFLOW);
            end else begin
              if (after_leaf && pend_lvl > 0) begin
                pend_lvl--;
                parent = pend_mem[pend_lvl] % NODE_CNT;
                node_mem[parent][8:0] = idx[8:0];
              end
              node_mem[idx] = b ? {1'b1, sym, 10'd0} : '0;
              used_cnt = idx + 1;
              if (!b) begin
                pend_mem[pend_lvl] = idx[9:0];
                pend_lvl++;
              end else if (pend_lvl == 0) begin
                tree_done = 1'b1;
                walk_idx  = 0;
              end
            end
          end
        end
        OP_BIT: begin
          if (!tree_done) begin
            push_decode('0, STAT_NO_TREE);
          end else if (node_mem[0][LEAF_POS]) begin
            push_decode(node_mem[0][17:10], STAT_OK);
          end else begin
            cur = walk_idx % NODE_CNT;
            nxt = b ? node_mem[cur][8:0] : cur + 1;
            if (nxt >= used_cnt) nxt = 0;
            ent = node_mem[nxt];
            if (ent[LEAF_POS]) begin
              walk_idx = 0;
              push_decode(ent[17:10], STAT_OK);
            end else begin
              walk_idx = nxt;
            end
          end
        end
        OP_CLEAR: begin
          pend_lvl  = 0;
          used_cnt  = 0;
          tree_done = 1'b0;
          walk_idx  = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_decode(logic [SYM_W-1:0] sym, logic [STAT_W-1:0] stat);
      decode_res_t due;
      if (decodes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected result symbol=%02h status=%0d", sym, stat);
      end else begin
        due = decodes_due.pop_front();
        if (sym !== due.sym || stat !== due.stat) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch symbol exp %02h got %02h, status exp %0d got %0d",
                     due.sym, sym, due.stat, stat);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // bit_req, leaf_symbol, zero pad
  logic [IN_USER_W-1:0]  in_tuser;   // operation
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // symbol
  logic [OUT_USER_W-1:0] out_tuser;  // status

  decode_scoreboard sb = new();
  bit               tx_idle;
  bit               rx_idle;
  int unsigned      sent_cnt;

  huffman_tree_load_and_decode_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_req(input logic [OP_W-1:0] op, input logic b,
                          input logic [SYM_W-1:0] sym);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, sym, b};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, b, sym);
    if (op != OP_UNUSED) sent_cnt++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.decodes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_req(OP_BIT, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      1: send_req(OP_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      2: send_req(OP_NODE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      default: send_req(OP_CLEAR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic run_session();
    int unsigned need;
    int unsigned n_int;
    int unsigned max_int;
    int unsigned n_bits;
    int unsigned k;
    tx_idle = $urandom_range(0, 3) != 0;
    rx_idle = $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 9) != 0)
      send_req(OP_CLEAR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    max_int = ($urandom_range(0, 29) == 0) ? $urandom_range(40, STACK_CNT - 1)
                                            : $urandom_range(0, 10);
    need  = 1;
    n_int = 0;
    while (need > 0) begin
      if (n_int < max_int && $urandom_range(0, 99) < 55) begin
        send_req(OP_NODE, 1'b0, 8'($urandom_range(0, 255)));
        need++;
        n_int++;
      end else begin
        send_req(OP_NODE, 1'b1, 8'($urandom_range(0, 255)));
        need--;
      end
      if ($urandom_range(0, 19) == 0) send_noise();
    end
    n_bits = $urandom_range(4, 60);
    for (k = 0; k < n_bits; k++) begin
      if ($urandom_range(0, 24) == 0)
        send_noise();
      else
        send_req(OP_BIT, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) drain_results();
  endtask

  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_decode(out_tdata, out_tuser);
    end
  end

  initial begin
    int unsigned i;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_NODE;
    out_tready <= 1'b0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    sent_cnt   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // bits with no tree, unused operation
    send_req(OP_BIT, 1'b0, 8'h00);
    send_req(OP_BIT, 1'b1, 8'hFF);
    send_req(OP_UNUSED, 1'b1, 8'hFF);
    // single leaf tree, then extra nodes
    send_req(OP_NODE, 1'b1, 8'hFF);
    send_req(OP_BIT, 1'b0, 8'h00);
    send_req(OP_BIT, 1'b1, 8'hFF);
    send_req(OP_NODE, 1'b1, 8'h11);
    send_req(OP_NODE, 1'b0, 8'h22);
    // three-leaf tree with a bit in the middle of the load
    send_req(OP_CLEAR, 1'b0, 8'h00);
    send_req(OP_NODE, 1'b0, 8'hFF);
    send_req(OP_NODE, 1'b1, 8'h00);
    send_req(OP_BIT, 1'b1, 8'h00);
    send_req(OP_NODE, 1'b0, 8'h00);
    send_req(OP_NODE, 1'b1, 8'hA5);
    send_req(OP_NODE, 1'b1, 8'h5A);
    send_req(OP_BIT, 1'b0, 8'h00);
    send_req(OP_BIT, 1'b1, 8'hFF);
    send_req(OP_BIT, 1'b0, 8'h00);
    send_req(OP_BIT, 1'b1, 8'h00);
    send_req(OP_BIT, 1'b1, 8'h00);
    drain_results();

    // fill the stack, overflow it, then fill the node store and overflow it
    tx_idle = 1'b0;
    send_req(OP_CLEAR, 1'b1, 8'h00);
    for (i = 0; i < STACK_CNT + 1; i++)
      send_req(OP_NODE, 1'b0, 8'($urandom_range(0, 255)));
    for (i = 0; i < NODE_CNT - STACK_CNT; i++)
      send_req(OP_NODE, 1'b1, 8'($urandom_range(0, 255)));
    send_req(OP_NODE, 1'b1, 8'h77);
    send_req(OP_NODE, 1'b0, 8'h88);
    send_req(OP_BIT, 1'b1, 8'h00);
    send_req(OP_CLEAR, 1'b0, 8'hFF);
    drain_results();

    while (sent_cnt < RANDOM_ITEMS) run_session();
    drain_results();

    if (sb.mismatches == 0 && sb.decodes_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hfd_pkg.sv
design/hfd_node_store.sv
design/hfd_stack.sv
design/huffman_tree_load_and_decode_core.sv
tb/tb.sv
